// File: src/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int MAX_ENTRIES_DEFAULT = 16;
  localparam int CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;
  } resp_t;

  typedef struct packed {
    logic load;
    logic match;
    logic update;
  } ctrl_t;

endpackage

// File: src/lkvc_ram.sv
// Generic single-port RAM with registered read data.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/lkvc_ctrl.sv
// Sequencer that steps each request through match, update and response.
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output ctrl_t ctrl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // A new request may enter while the previous response is on the ports.
  assign busy   = (state == S_MATCH) || (state == S_UPDATE);
  assign accept = start && !busy;
  assign done   = (state == S_RESP);

  assign ctrl.load   = accept;
  assign ctrl.match  = (state == S_MATCH);
  assign ctrl.update = (state == S_UPDATE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_MATCH;
      S_MATCH:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_RESP;
      S_RESP:   state_next = accept ? S_MATCH : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/lkvc_dp.sv
// Tag store, recency ranks, value RAM and response registers.
module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output resp_t            resp
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  req_t                    req_q;
  logic [CAP_W-1:0]        cap_q;
  logic [MAX_ENTRIES-1:0]  valid;
  logic [IDX_W-1:0]        rank [MAX_ENTRIES];
  logic [KEY_BITS-1:0]     keys [MAX_ENTRIES];
  logic [CNT_W-1:0]        used_cnt;

  logic                    hit_q;
  logic                    evict_q;
  logic [MAX_ENTRIES-1:0]  match_q;
  logic [MAX_ENTRIES-1:0]  victim_q;
  logic [IDX_W-1:0]        found_idx_q;
  logic [IDX_W-1:0]        found_rank_q;
  logic [KEY_BITS-1:0]     ev_key_q;

  logic [MAX_ENTRIES-1:0]  match_c;
  logic [MAX_ENTRIES-1:0]  victim_c;
  logic [IDX_W-1:0]        found_idx_c;
  logic [IDX_W-1:0]        found_rank_c;
  logic [IDX_W-1:0]        last_rank;
  logic                    full_c;
  logic [CMP_W-1:0]        used_ext;
  logic [CMP_W-1:0]        cap_ext;

  logic [MAX_ENTRIES-1:0]  victim_eff;
  logic [MAX_ENTRIES-1:0]  kept;
  logic [MAX_ENTRIES-1:0]  slot_oh;
  logic [IDX_W-1:0]        slot_idx;
  logic [KEY_BITS-1:0]     victim_key;

  logic                    is_set;
  logic                    ram_we;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_addr;
  logic [VALUE_BITS-1:0]   ram_rdata;

  assign is_set    = (req_q.cmd == CMD_SET);
  assign last_rank = IDX_W'(used_cnt - 1'b1);
  assign used_ext  = CMP_W'(used_cnt);
  assign cap_ext   = CMP_W'(cap_q);

  // Effective capacity: zero acts as one, anything above the store size saturates.
  always_comb begin
    if (cap_q == '0) begin
      full_c = (used_cnt != '0);
    end else if (cap_ext >= CMP_W'(MAX_ENTRIES)) begin
      full_c = (used_ext >= CMP_W'(MAX_ENTRIES));
    end else begin
      full_c = (used_ext >= cap_ext);
    end
  end

  always_comb begin
    found_idx_c  = '0;
    found_rank_c = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_c[i]  = valid[i] && (keys[i] == req_q.key);
      victim_c[i] = valid[i] && (rank[i] == last_rank);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        found_idx_c  = IDX_W'(i);
        found_rank_c = rank[i];
      end
    end
  end

  assign victim_eff = evict_q ? victim_q : '0;
  assign kept       = valid & ~victim_eff;

  // Lowest free slot once the victim, if any, has been released.
  always_comb begin
    slot_oh    = '0;
    slot_idx   = '0;
    victim_key = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!kept[i]) begin
        slot_oh  = '0;
        slot_oh[i] = 1'b1;
        slot_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim_key = victim_key | (keys[i] & {KEY_BITS{victim_q[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we) begin
      cap_q <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_q <= req;
    end
    if (ctrl.match) begin
      hit_q        <= |match_c;
      evict_q      <= is_set && !(|match_c) && full_c;
      match_q      <= match_c;
      victim_q     <= victim_c;
      found_idx_q  <= found_idx_c;
      found_rank_q <= found_rank_c;
    end
    if (ctrl.update) begin
      ev_key_q <= evict_q ? victim_key : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      used_cnt <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (ctrl.update) begin
      if (hit_q) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match_q[i]) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < found_rank_q)) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end else if (is_set) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_oh[i]) begin
            rank[i]  <= '0;
            valid[i] <= 1'b1;
          end else if (kept[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end else if (victim_eff[i]) begin
            valid[i] <= 1'b0;
          end
        end
        if (!evict_q) begin
          used_cnt <= used_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ctrl.update && is_set && !hit_q && slot_oh[i]) begin
        keys[i] <= req_q.key;
      end
    end
  end

  assign ram_we   = ctrl.update && is_set;
  assign ram_re   = ctrl.update && !is_set && hit_q;
  assign ram_addr = hit_q ? found_idx_q : slot_idx;

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (req_q.value),
    .rdata (ram_rdata)
  );

  assign resp.hit         = hit_q;
  assign resp.read_value  = (hit_q && !is_set) ? ram_rdata : '0;
  assign resp.evicted     = evict_q;
  assign resp.evicted_key = ev_key_q;

endmodule

// File: src/lru_key_value_cache.sv
// Top level of the fully associative key/value cache with LRU replacement.
// A request is taken when start is high and busy is low; its response appears
// on resp, flagged by done for exactly one cycle, once the tag compare and then
// the rank update and value RAM access are through. Busy is high during those
// steps, and a new request may be issued in the cycle that done is high. The
// receiver has no way to stall: each response must be taken when done is high.
// The capacity register may be written at any time cfg_valid is high (cfg_ready
// is always high) but should only change while no request is in flight. Values
// on a get miss and evicted keys without an eviction read as zero.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output resp_t            resp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  lkvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .resp     (resp)
  );

  // Every accepted request is answered with done once it has passed the match and update states.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##3 done)
    else $error("response missing three cycles after request");

  // A response is only produced at the end of a busy period.
  assert property (@(posedge clk) disable iff (rst) done |-> ($past(busy) && !busy))
    else $error("done without preceding busy period");

  // A hit never evicts.
  assert property (@(posedge clk) disable iff (rst) done |-> !(resp.hit && resp.evicted))
    else $error("hit and eviction reported together");

endmodule
